/* rtl/fwv_pkg.sv */
// Shared types, widths and constants of the four-wheel velocity PID core.
`timescale 1ns / 1ps
`default_nettype none
package fwv_pkg;

  localparam int NumWheels = 4;
  localparam int WheelW    = 2;
  localparam int CountW    = 32;
  localparam int VelW      = 24;
  localparam int GainW     = 16;
  localparam int LimW      = 15;
  localparam int SptW      = 24;
  localparam int HtW       = 16;
  localparam int DutyW     = 16;
  localparam int SumW      = 32;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 24;

  // Shared multiplier: 33-bit signed by 25-bit signed operand.
  localparam int MulAW = 33;
  localparam int MulBW = 25;
  localparam int ProdW = MulAW + MulBW;
  localparam int AccW  = 52;
  localparam int DqW   = AccW - 24;

  localparam int TermFrac  = 16;
  localparam int SpeedFrac = 8;
  localparam int DutyFrac  = 24;

  localparam logic [GainW-1:0] GainPReset = 16'd33280;
  localparam logic [GainW-1:0] GainIReset = 16'd10880;
  localparam logic [GainW-1:0] GainDReset = 16'd0;
  localparam logic [LimW-1:0]  LimReset   = 15'd155;
  localparam logic [SptW-1:0]  SptReset   = 24'd200847;
  localparam logic [HtW-1:0]   HtReset    = 16'd9149;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_DUTY_LIMIT     = 3'd3,
    REG_SPEED_PER_TICK = 3'd4,
    REG_HALF_TRACK     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GainW-1:0] gain_p;
    logic [GainW-1:0] gain_i;
    logic [GainW-1:0] gain_d;
    logic [LimW-1:0]  duty_limit;
    logic [SptW-1:0]  speed_per_tick;
    logic [HtW-1:0]   half_track;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_TERM  = 4'd2,
    OP_TGT   = 4'd3,
    OP_SPD   = 4'd4,
    OP_SPEED = 4'd5,
    OP_ERR   = 4'd6,
    OP_MP    = 4'd7,
    OP_MI    = 4'd8,
    OP_MD    = 4'd9,
    OP_ACC   = 4'd10,
    OP_DUTY  = 4'd11,
    OP_PUB   = 4'd12
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [WheelW-1:0] wheel;
  } cmd_t;

  typedef struct packed {
    logic signed [CountW-1:0] count_a;
    logic signed [CountW-1:0] count_b;
    logic signed [CountW-1:0] count_c;
    logic signed [CountW-1:0] count_d;
    logic signed [VelW-1:0]   linear_target;
    logic signed [VelW-1:0]   angular_target;
  } tick_t;

  typedef struct packed {
    logic signed [DutyW-1:0] duty_a;
    logic signed [DutyW-1:0] duty_b;
    logic signed [DutyW-1:0] duty_c;
    logic signed [DutyW-1:0] duty_d;
    logic signed [VelW-1:0]  speed_a;
    logic signed [VelW-1:0]  speed_b;
    logic signed [VelW-1:0]  speed_c;
    logic signed [VelW-1:0]  speed_d;
  } res_t;

  // Saturate a wide signed value to the Q7.16 velocity range.
  function automatic logic signed [VelW-1:0] sat_vel(input logic signed [ProdW-1:0] v);
    logic [ProdW-VelW:0] top;
    logic signed [VelW-1:0] r;
    top = v[ProdW-1:VelW-1];
    if ((&top) || !(|top)) begin
      r = v[VelW-1:0];
    end else if (v[ProdW-1]) begin
      r = {1'b1, {(VelW-1){1'b0}}};
    end else begin
      r = {1'b0, {(VelW-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a 33-bit sum to signed 32 bits.
  function automatic logic signed [SumW-1:0] sat_sum(input logic signed [SumW:0] v);
    logic signed [SumW-1:0] r;
    if (v[SumW] == v[SumW-1]) begin
      r = v[SumW-1:0];
    end else if (v[SumW]) begin
      r = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      r = {1'b0, {(SumW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/fwv_if.sv */
// Valid/ready channel interfaces for the tick item and the result item.
`timescale 1ns / 1ps
`default_nettype none
interface fwv_tick_if;
  logic valid;
  logic ready;
  logic signed [fwv_pkg::CountW-1:0] count_a;
  logic signed [fwv_pkg::CountW-1:0] count_b;
  logic signed [fwv_pkg::CountW-1:0] count_c;
  logic signed [fwv_pkg::CountW-1:0] count_d;
  logic signed [fwv_pkg::VelW-1:0]   linear_target;
  logic signed [fwv_pkg::VelW-1:0]   angular_target;

  modport source (output valid, count_a, count_b, count_c, count_d,
                  linear_target, angular_target, input ready);
  modport sink (input valid, count_a, count_b, count_c, count_d,
                linear_target, angular_target, output ready);
endinterface

interface fwv_res_if;
  logic valid;
  logic ready;
  logic signed [fwv_pkg::DutyW-1:0] duty_a;
  logic signed [fwv_pkg::DutyW-1:0] duty_b;
  logic signed [fwv_pkg::DutyW-1:0] duty_c;
  logic signed [fwv_pkg::DutyW-1:0] duty_d;
  logic signed [fwv_pkg::VelW-1:0]  speed_a;
  logic signed [fwv_pkg::VelW-1:0]  speed_b;
  logic signed [fwv_pkg::VelW-1:0]  speed_c;
  logic signed [fwv_pkg::VelW-1:0]  speed_d;

  modport source (output valid, duty_a, duty_b, duty_c, duty_d,
                  speed_a, speed_b, speed_c, speed_d, input ready);
  modport sink (input valid, duty_a, duty_b, duty_c, duty_d,
                speed_a, speed_b, speed_c, speed_d, output ready);
endinterface
`default_nettype wire

/* rtl/four_wheel_velocity_pid_core.sv */
// Top level of the four-wheel velocity PID core.
`timescale 1ns / 1ps
`default_nettype none
// Four-wheel velocity PID core. One tick item carries four encoder counts and
// the linear and angular speed targets; one result item carries the clamped
// duty and the measured speed of each wheel. Work goes through a single
// 33x25 signed multiplier that is shared by the target term and, per wheel,
// the speed product and the three PID gain products. After acceptance an item
// goes through a step for the count deltas, a step for the side targets, the
// eight-step wheel sequence on the shared multiplier for each wheel and a step
// that loads the result register, and the core then returns to idle, where the
// next item is taken. The next item is taken while a finished result still
// waits in the output register; the load of its own result then waits until
// that register has been drained. Configuration registers are to be written
// by the user through cfg_we, cfg_index and cfg_data while no item is in
// progress; the block does not enforce this. Other indexes are ignored.
module four_wheel_velocity_pid_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  fwv_tick_if.sink                           tick,
  fwv_res_if.source                          result,
  input  wire logic                          cfg_we,
  input  wire logic [fwv_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [fwv_pkg::CfgDataW-1:0]  cfg_data
);

  fwv_pkg::cfg_t  cfg;
  fwv_pkg::cmd_t  cmd;
  fwv_pkg::tick_t tick_item;
  fwv_pkg::res_t  res_item;
  logic           tick_ready;
  logic           res_valid;

  assign tick_item.count_a        = tick.count_a;
  assign tick_item.count_b        = tick.count_b;
  assign tick_item.count_c        = tick.count_c;
  assign tick_item.count_d        = tick.count_d;
  assign tick_item.linear_target  = tick.linear_target;
  assign tick_item.angular_target = tick.angular_target;
  assign tick.ready               = tick_ready;

  assign result.valid   = res_valid;
  assign result.duty_a  = res_item.duty_a;
  assign result.duty_b  = res_item.duty_b;
  assign result.duty_c  = res_item.duty_c;
  assign result.duty_d  = res_item.duty_d;
  assign result.speed_a = res_item.speed_a;
  assign result.speed_b = res_item.speed_b;
  assign result.speed_c = res_item.speed_c;
  assign result.speed_d = res_item.speed_d;

  fwv_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fwv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick_ready),
    .res_valid  (res_valid),
    .res_ready  (result.ready),
    .cmd        (cmd)
  );

  fwv_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cfg     (cfg),
    .tick_in (tick_item),
    .res_out (res_item)
  );

endmodule
`default_nettype wire

/* rtl/fwv_regs.sv */
// Configuration register bank of the four-wheel velocity PID core.
`timescale 1ns / 1ps
`default_nettype none
module fwv_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fwv_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [fwv_pkg::CfgDataW-1:0]  cfg_data,
  output fwv_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= fwv_pkg::GainPReset;
      cfg.gain_i         <= fwv_pkg::GainIReset;
      cfg.gain_d         <= fwv_pkg::GainDReset;
      cfg.duty_limit     <= fwv_pkg::LimReset;
      cfg.speed_per_tick <= fwv_pkg::SptReset;
      cfg.half_track     <= fwv_pkg::HtReset;
    end else if (cfg_we) begin
      // Indexes past the last register are dropped.
      case (fwv_pkg::reg_idx_t'(cfg_index))
        fwv_pkg::REG_GAIN_P:         cfg.gain_p         <= cfg_data[fwv_pkg::GainW-1:0];
        fwv_pkg::REG_GAIN_I:         cfg.gain_i         <= cfg_data[fwv_pkg::GainW-1:0];
        fwv_pkg::REG_GAIN_D:         cfg.gain_d         <= cfg_data[fwv_pkg::GainW-1:0];
        fwv_pkg::REG_DUTY_LIMIT:     cfg.duty_limit     <= cfg_data[fwv_pkg::LimW-1:0];
        fwv_pkg::REG_SPEED_PER_TICK: cfg.speed_per_tick <= cfg_data[fwv_pkg::SptW-1:0];
        fwv_pkg::REG_HALF_TRACK:     cfg.half_track     <= cfg_data[fwv_pkg::HtW-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/fwv_datapath.sv */
// Datapath: shared multiplier, wheel state and per-wheel PID arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module fwv_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  fwv_pkg::cmd_t       cmd,
  input  fwv_pkg::cfg_t       cfg,
  input  fwv_pkg::tick_t      tick_in,
  output fwv_pkg::res_t       res_out
);

  localparam int ProdW = fwv_pkg::ProdW;
  localparam int VelW  = fwv_pkg::VelW;
  localparam int SumW  = fwv_pkg::SumW;
  localparam int AccW  = fwv_pkg::AccW;
  localparam int DqW   = fwv_pkg::DqW;
  localparam int NW    = fwv_pkg::NumWheels;

  fwv_pkg::tick_t item;

  logic        [fwv_pkg::CountW-1:0] last_count [NW];
  logic signed [SumW-1:0]            error_sum  [NW];
  logic signed [VelW-1:0]            last_error [NW];
  logic signed [fwv_pkg::CountW-1:0] delta      [NW];
  logic signed [VelW-1:0]            speeds     [NW];
  logic signed [fwv_pkg::DutyW-1:0]  duty       [NW];
  logic        [fwv_pkg::CountW-1:0] counts     [NW];

  logic signed [VelW-1:0]  right_tgt;
  logic signed [VelW-1:0]  left_tgt;
  logic signed [VelW-1:0]  err;
  logic signed [SumW-1:0]  sum;
  logic signed [VelW:0]    der;
  logic signed [AccW-1:0]  acc;
  logic signed [ProdW-1:0] prod;

  logic signed [fwv_pkg::MulAW-1:0] mul_a;
  logic signed [fwv_pkg::MulBW-1:0] mul_b;

  logic signed [ProdW-1:0] bias16, bias8, prod_b16, prod_b8, prod_t16, prod_t8;
  logic signed [VelW-1:0]  term;
  logic signed [VelW:0]    r_sum, l_sum, e_diff, d_diff;
  logic signed [VelW-1:0]  tgt;
  logic signed [SumW:0]    s_add;
  logic signed [AccW-1:0]  prod_acc, acc_bias, acc_b, acc_t;
  logic signed [DqW-1:0]   dq, lim_s, lim_n;
  logic signed [fwv_pkg::DutyW-1:0] duty_c;

  assign counts[0] = item.count_a;
  assign counts[1] = item.count_b;
  assign counts[2] = item.count_c;
  assign counts[3] = item.count_d;

  // Operand selection for the single shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      fwv_pkg::OP_TERM: begin
        mul_a = fwv_pkg::MulAW'(item.angular_target);
        mul_b = fwv_pkg::MulBW'(cfg.half_track);
      end
      fwv_pkg::OP_SPD: begin
        mul_a = fwv_pkg::MulAW'(delta[cmd.wheel]);
        mul_b = fwv_pkg::MulBW'(cfg.speed_per_tick);
      end
      fwv_pkg::OP_MP: begin
        mul_a = fwv_pkg::MulAW'(err);
        mul_b = fwv_pkg::MulBW'(cfg.gain_p);
      end
      fwv_pkg::OP_MI: begin
        mul_a = fwv_pkg::MulAW'(sum);
        mul_b = fwv_pkg::MulBW'(cfg.gain_i);
      end
      fwv_pkg::OP_MD: begin
        mul_a = fwv_pkg::MulAW'(der);
        mul_b = fwv_pkg::MulBW'(cfg.gain_d);
      end
      default: ;
    endcase
  end

  // Shifts that truncate toward zero: negative values get a bias first.
  assign bias16   = {{(ProdW-fwv_pkg::TermFrac){1'b0}}, {fwv_pkg::TermFrac{prod[ProdW-1]}}};
  assign bias8    = {{(ProdW-fwv_pkg::SpeedFrac){1'b0}}, {fwv_pkg::SpeedFrac{prod[ProdW-1]}}};
  assign prod_b16 = prod + bias16;
  assign prod_b8  = prod + bias8;
  assign prod_t16 = prod_b16 >>> fwv_pkg::TermFrac;
  assign prod_t8  = prod_b8 >>> fwv_pkg::SpeedFrac;
  assign term     = prod_t16[VelW-1:0];

  assign r_sum = (VelW+1)'(item.linear_target) + (VelW+1)'(term);
  assign l_sum = (VelW+1)'(item.linear_target) - (VelW+1)'(term);

  // Wheels A and D are on the right side.
  assign tgt    = (cmd.wheel == 2'd0 || cmd.wheel == 2'd3) ? right_tgt : left_tgt;
  assign e_diff = (VelW+1)'(tgt) - (VelW+1)'(speeds[cmd.wheel]);
  assign s_add  = (SumW+1)'(error_sum[cmd.wheel]) + (SumW+1)'(err);
  assign d_diff = (VelW+1)'(err) - (VelW+1)'(last_error[cmd.wheel]);

  assign prod_acc = prod[AccW-1:0];
  assign acc_bias = {{(AccW-fwv_pkg::DutyFrac){1'b0}}, {fwv_pkg::DutyFrac{acc[AccW-1]}}};
  assign acc_b    = acc + acc_bias;
  assign acc_t    = acc_b >>> fwv_pkg::DutyFrac;
  assign dq       = acc_t[DqW-1:0];
  assign lim_s    = DqW'(cfg.duty_limit);
  assign lim_n    = -lim_s;

  always_comb begin
    if (dq > lim_s) begin
      duty_c = lim_s[fwv_pkg::DutyW-1:0];
    end else if (dq < lim_n) begin
      duty_c = lim_n[fwv_pkg::DutyW-1:0];
    end else begin
      duty_c = dq[fwv_pkg::DutyW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Wheel history is reset; working registers are not.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NW; i++) begin
        last_count[i] <= '0;
        error_sum[i]  <= '0;
        last_error[i] <= '0;
      end
    end else begin
      if (cmd.op == fwv_pkg::OP_TERM) begin
        for (int i = 0; i < NW; i++) begin
          last_count[i] <= counts[i];
        end
      end
      if (cmd.op == fwv_pkg::OP_DUTY) begin
        error_sum[cmd.wheel]  <= sum;
        last_error[cmd.wheel] <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      fwv_pkg::OP_LOAD: item <= tick_in;
      fwv_pkg::OP_TERM: begin
        for (int i = 0; i < NW; i++) begin
          delta[i] <= counts[i] - last_count[i];
        end
      end
      fwv_pkg::OP_TGT: begin
        right_tgt <= fwv_pkg::sat_vel(ProdW'(r_sum));
        left_tgt  <= fwv_pkg::sat_vel(ProdW'(l_sum));
      end
      fwv_pkg::OP_SPEED: speeds[cmd.wheel] <= fwv_pkg::sat_vel(prod_t8);
      fwv_pkg::OP_ERR:   err <= fwv_pkg::sat_vel(ProdW'(e_diff));
      fwv_pkg::OP_MP: begin
        sum <= fwv_pkg::sat_sum(s_add);
        der <= d_diff;
      end
      fwv_pkg::OP_MI:   acc <= prod_acc;
      fwv_pkg::OP_MD:   acc <= acc + prod_acc;
      fwv_pkg::OP_ACC:  acc <= acc + prod_acc;
      fwv_pkg::OP_DUTY: duty[cmd.wheel] <= duty_c;
      fwv_pkg::OP_PUB: begin
        res_out.duty_a  <= duty[0];
        res_out.duty_b  <= duty[1];
        res_out.duty_c  <= duty[2];
        res_out.duty_d  <= duty[3];
        res_out.speed_a <= speeds[0];
        res_out.speed_b <= speeds[1];
        res_out.speed_c <= speeds[2];
        res_out.speed_d <= speeds[3];
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/fwv_ctrl.sv */
// Controller: sequences the shared multiplier over the four wheels.
`timescale 1ns / 1ps
`default_nettype none
module fwv_ctrl (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   tick_valid,
  output logic        tick_ready,
  output logic        res_valid,
  input  wire logic   res_ready,
  output fwv_pkg::cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_TERM  = 12'b0000_0000_0010,
    S_TGT   = 12'b0000_0000_0100,
    S_SPD   = 12'b0000_0000_1000,
    S_SPEED = 12'b0000_0001_0000,
    S_ERR   = 12'b0000_0010_0000,
    S_MP    = 12'b0000_0100_0000,
    S_MI    = 12'b0000_1000_0000,
    S_MD    = 12'b0001_0000_0000,
    S_ACC   = 12'b0010_0000_0000,
    S_DUTY  = 12'b0100_0000_0000,
    S_PUB   = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic [fwv_pkg::WheelW-1:0] wheel, wheel_next;
  logic res_valid_next;
  logic pub_fire;

  assign tick_ready = (state == S_IDLE);
  // The result register can be refilled when empty or being drained.
  assign pub_fire   = (state == S_PUB) && (!res_valid || res_ready);

  always_comb begin
    state_next = state;
    wheel_next = wheel;
    cmd.op     = fwv_pkg::OP_NONE;
    cmd.wheel  = wheel;
    case (state)
      S_IDLE: begin
        if (tick_valid) begin
          cmd.op     = fwv_pkg::OP_LOAD;
          state_next = S_TERM;
        end
      end
      S_TERM: begin
        cmd.op     = fwv_pkg::OP_TERM;
        state_next = S_TGT;
      end
      S_TGT: begin
        cmd.op     = fwv_pkg::OP_TGT;
        state_next = S_SPD;
      end
      S_SPD: begin
        cmd.op     = fwv_pkg::OP_SPD;
        state_next = S_SPEED;
      end
      S_SPEED: begin
        cmd.op     = fwv_pkg::OP_SPEED;
        state_next = S_ERR;
      end
      S_ERR: begin
        cmd.op     = fwv_pkg::OP_ERR;
        state_next = S_MP;
      end
      S_MP: begin
        cmd.op     = fwv_pkg::OP_MP;
        state_next = S_MI;
      end
      S_MI: begin
        cmd.op     = fwv_pkg::OP_MI;
        state_next = S_MD;
      end
      S_MD: begin
        cmd.op     = fwv_pkg::OP_MD;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = fwv_pkg::OP_ACC;
        state_next = S_DUTY;
      end
      S_DUTY: begin
        cmd.op     = fwv_pkg::OP_DUTY;
        wheel_next = wheel + 1'b1;
        state_next = (wheel == 2'(fwv_pkg::NumWheels - 1)) ? S_PUB : S_SPD;
      end
      S_PUB: begin
        if (pub_fire) begin
          cmd.op     = fwv_pkg::OP_PUB;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        wheel_next = '0;
      end
    endcase
  end

  always_comb begin
    res_valid_next = res_valid;
    if (pub_fire) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wheel     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wheel     <= wheel_next;
      res_valid <= res_valid_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/fwv_checker.sv */
// Port-level checks on the four-wheel velocity PID core and their binding.
`timescale 1ns / 1ps
`default_nettype none
module fwv_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         tick_valid,
  input wire logic         tick_ready,
  input wire logic         res_valid,
  input wire logic         res_ready,
  input wire logic [159:0] res_payload
);

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick ready stayed high after an item was accepted");

  // A result cannot appear in the cycle right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !$rose(res_valid))
    else $error("result appeared directly after an accepted item");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_payload))
    else $error("result payload changed while stalled");

endmodule

bind four_wheel_velocity_pid_core fwv_checker u_fwv_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick.valid),
  .tick_ready  (tick.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_payload ({result.duty_a, result.duty_b, result.duty_c, result.duty_d,
                 result.speed_a, result.speed_b, result.speed_c, result.speed_d})
);
`default_nettype wire
